// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the image view block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is low.
`define IRPTC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property check failed");

// Condition that must never be seen at a clock edge.
`define IRPTC_ASSERT_NEVER(lbl, clk, rstn, expr) \
    `IRPTC_ASSERT(lbl, clk, rstn, !(expr))

`endif

// ===== hdl/irptc_pkg.sv =====
// Shared types and codes of the rotate / pad / tile / crop image view.
// Depends on nothing; the remainder unit, the top level and the checker refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package irptc_pkg;

    localparam int ROW_W = 16;
    localparam int PIX_W = 8;
    localparam int DIM_W = 9;
    localparam int ARG_W = 8;
    localparam int SIZE_W = 16;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_CW   = 3'd0,
        OP_CCW  = 3'd1,
        OP_PAD  = 3'd2,
        OP_TILE = 3'd3,
        OP_CROP = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    localparam logic MODE_WRITE = 1'b0;

    localparam logic [2:0] CFG_OPERATION  = 3'd0;
    localparam logic [2:0] CFG_IMAGE_ROWS = 3'd1;
    localparam logic [2:0] CFG_IMAGE_COLS = 3'd2;
    localparam logic [2:0] CFG_ARG_ROW    = 3'd3;
    localparam logic [2:0] CFG_ARG_COL    = 3'd4;
    localparam logic [2:0] CFG_ARG_HEIGHT = 3'd5;
    localparam logic [2:0] CFG_ARG_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_PAD_VALUE  = 3'd7;

    typedef struct packed {
        logic             start;
        logic [ROW_W-1:0] dividend;
        logic [DIM_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] rem;
    } mod_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/irptc_mod_unit.sv =====
// Iterative remainder unit: one compare-and-subtract per cycle.
// Depends on irptc_pkg. The dividend must be below divisor * 256.
`timescale 1ns / 1ps
`default_nettype none

module irptc_mod_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire irptc_pkg::mod_req_t req,
    output irptc_pkg::mod_rsp_t     rsp
);

    logic [15:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend;
            dsr_next  = {req.divisor, 7'b0};
            cnt_next  = 3'd7;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // subtract the shifted divisor when it fits, then shift it down
            if (rem_reg >= dsr_reg)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            dsr_next = dsr_reg >> 1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[8:0];

endmodule

`default_nettype wire

// ===== hdl/irptc_frame_mem.sv =====
// Single-port frame store, 8-bit pixels, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module irptc_frame_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/image_rotate_pad_tile_crop.sv =====
// Top level of the rotate / pad / tile / crop view over an 8-bit frame store.
// Depends on irptc_pkg, irptc_mod_unit and irptc_frame_mem.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+----------------------------------
//  s_*      | in        | s_tvalid/s_tready  | one write or read request word
//  m_*      | out       | m_tvalid/m_tready  | one result word per request
//  cfg_*    | in        | cfg_we (no wait)   | register index and value
//
// A write passes S_SIZE, S_MAP, S_ADDR, S_MEM and S_DONE; a plain read adds
// S_WAIT after S_MEM and a tile read S_MODR and S_MODC before S_ADDR, where
// the remainder unit does eight compare-and-subtract steps for the row, then
// for the column. A read needing no store access (pad border, outside,
// invalid) and a write outside the store go from S_MAP to S_DONE. One
// request is in work at a time; s_tready is high only when idle. A finished
// result sits in the output register; the next request is taken while it
// waits, and that request stalls at its end until the register frees. Reset
// clears control and settings; the frame store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module image_rotate_pad_tile_crop #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request: tdata = row[15:0], col[31:16], pixel_in[39:32]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic [0:0]  s_tuser,   // mode (0 write, 1 read)
    // result: tdata = pixel_out[7:0], out_rows[23:8], out_cols[39:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,
    output logic      [1:0]  m_tuser,   // status
    // settings
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIZE,
        S_MAP,
        S_MODR,
        S_MODC,
        S_ADDR,
        S_MEM,
        S_WAIT,
        S_DONE
    } state_t;

    // ---------------------------------------------------------------- settings
    logic [2:0] op_reg;
    logic [8:0] img_rows_reg;
    logic [8:0] img_cols_reg;
    logic [7:0] arg_row_reg;
    logic [7:0] arg_col_reg;
    logic [8:0] arg_height_reg;
    logic [8:0] arg_width_reg;
    logic [7:0] pad_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= irptc_pkg::OP_CW;
            img_rows_reg   <= 9'd1;
            img_cols_reg   <= 9'd1;
            arg_row_reg    <= 8'd0;
            arg_col_reg    <= 8'd0;
            arg_height_reg <= 9'd0;
            arg_width_reg  <= 9'd0;
            pad_value_reg  <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irptc_pkg::CFG_OPERATION:  op_reg         <= cfg_data[2:0];
                irptc_pkg::CFG_IMAGE_ROWS: img_rows_reg   <= cfg_data;
                irptc_pkg::CFG_IMAGE_COLS: img_cols_reg   <= cfg_data;
                irptc_pkg::CFG_ARG_ROW:    arg_row_reg    <= cfg_data[7:0];
                irptc_pkg::CFG_ARG_COL:    arg_col_reg    <= cfg_data[7:0];
                irptc_pkg::CFG_ARG_HEIGHT: arg_height_reg <= cfg_data;
                irptc_pkg::CFG_ARG_WIDTH:  arg_width_reg  <= cfg_data;
                irptc_pkg::CFG_PAD_VALUE:  pad_value_reg  <= cfg_data[7:0];
                default:                   op_reg         <= op_reg;
            endcase
        end
    end

    // ------------------------------------------------------- output image size
    // Unsaturated 17-bit sizes so bounds checks stay exact past 65535.
    logic        ok_c;
    logic [16:0] rows_c;
    logic [16:0] cols_c;
    logic        dims_ok;

    always_comb
    begin
        dims_ok = (img_rows_reg != 9'd0) && (img_cols_reg != 9'd0)
            && (32'(img_rows_reg) <= MAX_ROWS) && (32'(img_cols_reg) <= MAX_COLS);
        ok_c   = dims_ok;
        rows_c = 17'd0;
        cols_c = 17'd0;
        case (op_reg)
            irptc_pkg::OP_CW, irptc_pkg::OP_CCW:
            begin
                rows_c = 17'(img_cols_reg);
                cols_c = 17'(img_rows_reg);
            end
            irptc_pkg::OP_PAD:
            begin
                rows_c = 17'(img_rows_reg) + 17'({arg_row_reg, 1'b0});
                cols_c = 17'(img_cols_reg) + 17'({arg_row_reg, 1'b0});
            end
            irptc_pkg::OP_TILE:
            begin
                if (arg_row_reg == 8'd0 || arg_col_reg == 8'd0)
                begin
                    ok_c = 1'b0;
                end
                rows_c = 17'(img_rows_reg) * 17'(arg_row_reg);
                cols_c = 17'(img_cols_reg) * 17'(arg_col_reg);
            end
            irptc_pkg::OP_CROP:
            begin
                if ((10'(arg_row_reg) + 10'(arg_height_reg) > 10'(img_rows_reg))
                    || (10'(arg_col_reg) + 10'(arg_width_reg) > 10'(img_cols_reg)))
                begin
                    ok_c = 1'b0;
                end
                rows_c = 17'(arg_height_reg);
                cols_c = 17'(arg_width_reg);
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
        if (!ok_c)
        begin
            rows_c = 17'd0;
            cols_c = 17'd0;
        end
    end

    // -------------------------------------------------------- shared units
    irptc_pkg::mod_req_t mod_req;
    irptc_pkg::mod_rsp_t mod_rsp;

    irptc_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    logic          mem_en;
    logic          mem_we;
    logic [7:0]    mem_rdata;
    logic [AW-1:0] addr_reg, addr_next;

    // ---------------------------------------------------------- sequencer
    state_t        state_reg, state_next;
    logic          mode_reg, mode_next;
    logic [15:0]   row_reg, row_next;
    logic [15:0]   col_reg, col_next;
    logic [7:0]    pin_reg, pin_next;
    logic          ok_reg, ok_next;
    logic [16:0]   rows_reg, rows_next;
    logic [16:0]   cols_reg, cols_next;
    logic [RW-1:0] src_r_reg, src_r_next;
    logic [CW-1:0] src_c_reg, src_c_next;
    logic [1:0]    stat_reg, stat_next;
    logic [7:0]    pix_reg, pix_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_pix_reg, m_pix_next;
    logic [1:0]    m_stat_reg, m_stat_next;
    logic [15:0]   m_rows_reg, m_rows_next;
    logic [15:0]   m_cols_reg, m_cols_next;

    logic out_free;
    logic outside;
    logic in_pad;
    logic wr_in_store;

    always_comb
    begin
        out_free = !m_valid_reg || m_tready;
        outside  = (17'(row_reg) >= rows_reg) || (17'(col_reg) >= cols_reg);
        in_pad   = (row_reg < 16'(arg_row_reg))
            || (17'(row_reg) >= 17'(img_rows_reg) + 17'(arg_row_reg))
            || (col_reg < 16'(arg_row_reg))
            || (17'(col_reg) >= 17'(img_cols_reg) + 17'(arg_row_reg));
        wr_in_store = (32'(row_reg) < MAX_ROWS) && (32'(col_reg) < MAX_COLS);

        state_next   = state_reg;
        mode_next    = mode_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        pin_next     = pin_reg;
        ok_next      = ok_reg;
        rows_next    = rows_reg;
        cols_next    = cols_reg;
        src_r_next   = src_r_reg;
        src_c_next   = src_c_reg;
        stat_next    = stat_reg;
        pix_next     = pix_reg;
        addr_next    = addr_reg;
        m_pix_next   = m_pix_reg;
        m_stat_next  = m_stat_reg;
        m_rows_next  = m_rows_reg;
        m_cols_next  = m_cols_reg;
        m_valid_next = m_valid_reg && !m_tready;

        mod_req.start    = 1'b0;
        mod_req.dividend = row_reg;
        mod_req.divisor  = img_rows_reg;
        mem_en = 1'b0;
        mem_we = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser[0];
                    row_next   = s_tdata[15:0];
                    col_next   = s_tdata[31:16];
                    pin_next   = s_tdata[39:32];
                    pix_next   = 8'd0;
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                ok_next    = ok_c;
                rows_next  = rows_c;
                cols_next  = cols_c;
                state_next = S_MAP;
            end
            S_MAP:
            begin
                stat_next  = irptc_pkg::ST_OK;
                src_r_next = RW'(row_reg);
                src_c_next = CW'(col_reg);
                state_next = S_DONE;
                if (mode_reg == irptc_pkg::MODE_WRITE)
                begin
                    // the write lands even under invalid settings
                    if (wr_in_store)
                    begin
                        state_next = S_ADDR;
                    end
                    else
                    begin
                        stat_next = irptc_pkg::ST_OUTSIDE;
                    end
                    if (!ok_reg)
                    begin
                        stat_next = irptc_pkg::ST_INVALID;
                    end
                end
                else if (!ok_reg)
                begin
                    stat_next = irptc_pkg::ST_INVALID;
                end
                else if (outside)
                begin
                    stat_next = irptc_pkg::ST_OUTSIDE;
                end
                else
                begin
                    state_next = S_ADDR;
                    case (op_reg)
                        irptc_pkg::OP_CW:
                        begin
                            src_r_next = RW'(16'(img_rows_reg) - 16'd1 - col_reg);
                            src_c_next = CW'(row_reg);
                        end
                        irptc_pkg::OP_CCW:
                        begin
                            src_r_next = RW'(col_reg);
                            src_c_next = CW'(16'(img_cols_reg) - 16'd1 - row_reg);
                        end
                        irptc_pkg::OP_PAD:
                        begin
                            if (in_pad)
                            begin
                                pix_next   = pad_value_reg;
                                state_next = S_DONE;
                            end
                            src_r_next = RW'(row_reg - 16'(arg_row_reg));
                            src_c_next = CW'(col_reg - 16'(arg_row_reg));
                        end
                        irptc_pkg::OP_TILE:
                        begin
                            // fold the row first, the column follows
                            mod_req.start = 1'b1;
                            state_next    = S_MODR;
                        end
                        default:
                        begin
                            src_r_next = RW'(16'(arg_row_reg) + row_reg);
                            src_c_next = CW'(16'(arg_col_reg) + col_reg);
                        end
                    endcase
                end
            end
            S_MODR:
            begin
                mod_req.dividend = col_reg;
                mod_req.divisor  = img_cols_reg;
                if (mod_rsp.done)
                begin
                    src_r_next    = RW'(mod_rsp.rem);
                    mod_req.start = 1'b1;
                    state_next    = S_MODC;
                end
            end
            S_MODC:
            begin
                if (mod_rsp.done)
                begin
                    src_c_next = CW'(mod_rsp.rem);
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                addr_next  = AW'(32'(src_r_reg) * MAX_COLS + 32'(src_c_reg));
                state_next = S_MEM;
            end
            S_MEM:
            begin
                mem_en = 1'b1;
                mem_we = (mode_reg == irptc_pkg::MODE_WRITE);
                state_next = mem_we ? S_DONE : S_WAIT;
            end
            S_WAIT:
            begin
                pix_next   = mem_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold here until the output register is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_pix_next   = pix_reg;
                    m_stat_next  = stat_reg;
                    m_rows_next  = rows_reg[16] ? irptc_pkg::SIZE_MAX : rows_reg[15:0];
                    m_cols_next  = cols_reg[16] ? irptc_pkg::SIZE_MAX : cols_reg[15:0];
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            mode_reg    <= 1'b0;
            row_reg     <= 16'd0;
            col_reg     <= 16'd0;
            pin_reg     <= 8'd0;
            ok_reg      <= 1'b0;
            rows_reg    <= 17'd0;
            cols_reg    <= 17'd0;
            src_r_reg   <= '0;
            src_c_reg   <= '0;
            stat_reg    <= irptc_pkg::ST_OK;
            pix_reg     <= 8'd0;
            addr_reg    <= '0;
            m_pix_reg   <= 8'd0;
            m_stat_reg  <= irptc_pkg::ST_OK;
            m_rows_reg  <= 16'd0;
            m_cols_reg  <= 16'd0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mode_reg    <= mode_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            pin_reg     <= pin_next;
            ok_reg      <= ok_next;
            rows_reg    <= rows_next;
            cols_reg    <= cols_next;
            src_r_reg   <= src_r_next;
            src_c_reg   <= src_c_next;
            stat_reg    <= stat_next;
            pix_reg     <= pix_next;
            addr_reg    <= addr_next;
            m_pix_reg   <= m_pix_next;
            m_stat_reg  <= m_stat_next;
            m_rows_reg  <= m_rows_next;
            m_cols_reg  <= m_cols_next;
        end
    end

    irptc_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (addr_reg),
        .wdata (pin_reg),
        .rdata (mem_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_cols_reg, m_rows_reg, m_pix_reg};
    assign m_tuser  = m_stat_reg;

endmodule

`default_nettype wire

// ===== hdl/irptc_checker.sv =====
// Port-level checks of the image view block, attached by bind.
// Depends on irptc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module irptc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled result word holds
    `IRPTC_ASSERT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

    // one request in work at a time: ready drops after every accept
    `IRPTC_ASSERT(a_one_in_work, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready)

    // a pixel is given only with an ok status
    `IRPTC_ASSERT_NEVER(a_pix_zero, clk, rst_n, m_tvalid && (m_tuser != irptc_pkg::ST_OK) && (m_tdata[7:0] != 8'd0))

    // invalid settings report an empty output image
    `IRPTC_ASSERT_NEVER(a_size_zero, clk, rst_n, m_tvalid && (m_tuser == irptc_pkg::ST_INVALID) && (m_tdata[39:8] != 32'd0))

endmodule

bind image_rotate_pad_tile_crop irptc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
